[src/smcs_pkg.sv]
`timescale 1ns / 1ps

package smcs_pkg;

    localparam logic [3:0]  TX_ENTRIES = 4'd10;
    localparam logic [3:0]  RX_ENTRIES = 4'd7;

    localparam logic [10:0] SDO_REQ_BASE  = 11'h600;
    localparam logic [7:0]  REPLY_ABORT   = 8'h80;
    localparam logic [7:0]  REPLY_SUCCESS = 8'h60;
    localparam logic [7:0]  CMD_WRITE4    = 8'h23;
    localparam logic [7:0]  IDX_MAP_CLEAR = 8'h31;
    localparam logic [7:0]  IDX_MAP_ENTRY = 8'h30;
    localparam logic [7:0]  IDX_SAVE      = 8'h50;
    localparam logic [7:0]  DIR_TX        = 8'h00;
    localparam logic [7:0]  DIR_RX        = 8'h01;
    localparam logic [7:0]  DIR_SAVE      = 8'h02;
    localparam logic [7:0]  CLEAR_TX_SEL  = 8'h00;
    localparam logic [7:0]  CLEAR_RX_SEL  = 8'h80;
    localparam logic [15:0] GAIN_OFFSET   = 16'h03E8;
    localparam logic [7:0]  ABORT_LIMIT   = 8'd4;

    localparam logic [1:0]  SUB_ID     = 2'd0;
    localparam logic [1:0]  SUB_LAYOUT = 2'd1;
    localparam logic [1:0]  SUB_GAIN   = 2'd2;
    localparam logic [1:0]  SUB_STALL  = 2'd3;

    typedef enum logic [2:0] {
        PH_CLEAR_TX = 3'd0,
        PH_CLEAR_RX = 3'd1,
        PH_TX_MAP   = 3'd2,
        PH_RX_MAP   = 3'd3,
        PH_SAVE     = 3'd4,
        PH_DONE     = 3'd5
    } phase_t;

    // bytes 7..0 of one map row
    function automatic logic [63:0] tx_row(input logic [3:0] idx);
        logic [63:0] row;
        case (idx)
            4'd0:    row = 64'h1000_07D6_0000_0109;
            4'd1:    row = 64'h1010_07DA_0000_0109;
            4'd2:    row = 64'h1020_07D8_0000_0109;
            4'd3:    row = 64'h1030_07D9_0000_0109;
            4'd4:    row = 64'h0800_07EC_0000_0357;
            4'd5:    row = 64'h1008_07E5_0000_0357;
            4'd6:    row = 64'h0818_07EE_0000_0357;
            4'd7:    row = 64'h0820_07E8_0000_0357;
            4'd8:    row = 64'h0828_07DE_0000_0357;
            4'd9:    row = 64'h0830_07E4_0000_0357;
            default: row = 64'h0;
        endcase
        return row;
    endfunction

    function automatic logic [63:0] rx_row(input logic [3:0] idx);
        logic [63:0] row;
        case (idx)
            4'd0:    row = 64'h0100_0017_0000_0358;
            4'd1:    row = 64'h0402_001D_0000_0358;
            4'd2:    row = 64'h0808_0005_0000_0358;
            4'd3:    row = 64'h1010_0006_0000_0358;
            4'd4:    row = 64'h1020_0003_0000_0358;
            4'd5:    row = 64'h1030_0004_0000_0358;
            4'd6:    row = 64'h0107_0020_0000_0358;
            default: row = 64'h0;
        endcase
        return row;
    endfunction

endpackage

[src/smcs_ifs.sv]
`timescale 1ns / 1ps

interface smcs_in_if;
    logic       valid;
    logic       ready;
    logic       func;
    logic       enabled;
    logic [7:0] reply_code;

    modport source (output valid, output func, output enabled, output reply_code,
                    input ready);
    modport sink   (input valid, input func, input enabled, input reply_code,
                    output ready);
endinterface

interface smcs_out_if;
    logic        valid;
    logic        ready;
    logic        send_frame;
    logic [10:0] frame_id;
    logic [63:0] payload;
    logic        config_done;

    modport source (output valid, output send_frame, output frame_id, output payload,
                    output config_done, input ready);
    modport sink   (input valid, input send_frame, input frame_id, input payload,
                    input config_done, output ready);
endinterface

[src/sdo_mapping_config_sequencer.sv]
`timescale 1ns / 1ps

// sdo mapping configuration sequencer
// in_ch carries one word per 10 ms tick (func 0) or per received sdo reply
// (func 1, reply_code = first reply byte). out_ch returns exactly one word
// for every input word: send_frame with frame_id and payload when a request
// frame goes out, config_done on an enabled tick once the sequence is over.
// cfg_we / cfg_wdata set the remote node number; write it only while idle.
// the result word is registered and valid the cycle after its input is taken.
// throughput: one word per cycle unless out_ch stalls; all sequencing is a
// single combinational pass from the held state and the input word into the
// state and the output register.
// a stalled receiver holds the output register; in_ch.ready stays high
// while the output register is empty or being drained in the same cycle.
// reset clears the sequence to the clear-tx step, no reply outstanding,
// abort count zero, output register empty and node number 1.
module sdo_mapping_config_sequencer (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_we,
    input  logic [6:0] cfg_wdata,
    smcs_in_if.sink    in_ch,
    smcs_out_if.source out_ch
);
    import smcs_pkg::*;

    phase_t      phase_reg, phase_next;
    logic [1:0]  sub_write_reg, sub_write_next;
    logic [3:0]  entry_index_reg, entry_index_next;
    logic        awaiting_reply_reg, awaiting_reply_next;
    logic        empty_seen_reg, empty_seen_next;
    logic        success_seen_reg, success_seen_next;
    logic [7:0]  abort_run_reg, abort_run_next;
    logic [6:0]  node_id_reg;

    logic        out_valid_reg;
    logic        send_frame_reg;
    logic [10:0] frame_id_reg;
    logic [63:0] payload_reg;
    logic        config_done_reg;

    logic        accept;
    logic        sent;
    logic [63:0] sent_payload;
    logic        done;
    logic [3:0]  entry_count;
    logic [63:0] row;
    logic [7:0]  dir;
    logic [1:0]  sub_sel;
    logic        skip_req;

    assign in_ch.ready = !out_valid_reg || out_ch.ready;
    assign accept      = in_ch.valid && in_ch.ready;

    always_comb
    begin
        phase_next          = phase_reg;
        sub_write_next      = sub_write_reg;
        entry_index_next    = entry_index_reg;
        awaiting_reply_next = awaiting_reply_reg;
        empty_seen_next     = empty_seen_reg;
        success_seen_next   = success_seen_reg;
        abort_run_next      = abort_run_reg;
        sent                = 1'b0;
        sent_payload        = 64'h0;
        done                = 1'b0;
        entry_count         = (phase_reg == PH_RX_MAP) ? RX_ENTRIES : TX_ENTRIES;
        row                 = (phase_reg == PH_RX_MAP) ? rx_row(entry_index_reg)
                                                       : tx_row(entry_index_reg);
        dir                 = (phase_reg == PH_RX_MAP) ? DIR_RX : DIR_TX;
        sub_sel             = sub_write_reg;
        skip_req            = 1'b0;

        if (in_ch.func)
        begin
            if (awaiting_reply_reg)
            begin
                if (in_ch.reply_code == REPLY_ABORT)
                begin
                    empty_seen_next = 1'b1;
                    abort_run_next  = abort_run_reg + 8'd1;
                end
                else if (in_ch.reply_code == REPLY_SUCCESS)
                begin
                    success_seen_next = 1'b1;
                    abort_run_next    = 8'd0;
                end
                else
                begin
                    abort_run_next = 8'd0;
                end
                awaiting_reply_next = 1'b0;
                if (abort_run_next > ABORT_LIMIT)
                    phase_next = PH_DONE;
            end
        end
        else if (in_ch.enabled)
        begin
            unique case (phase_reg)
                PH_CLEAR_TX, PH_CLEAR_RX:
                begin
                    if (!awaiting_reply_reg && !empty_seen_reg)
                    begin
                        sent         = 1'b1;
                        sent_payload = {40'h0, IDX_MAP_CLEAR,
                                        (phase_reg == PH_CLEAR_TX) ? CLEAR_TX_SEL
                                                                   : CLEAR_RX_SEL,
                                        CMD_WRITE4};
                    end
                    if (empty_seen_reg)
                    begin
                        empty_seen_next = 1'b0;
                        if (phase_reg == PH_CLEAR_RX)
                        begin
                            sub_write_next    = SUB_ID;
                            success_seen_next = 1'b0;
                        end
                        phase_next = phase_t'(phase_reg + 3'd1);
                    end
                end
                PH_TX_MAP, PH_RX_MAP:
                begin
                    if (entry_index_reg < entry_count)
                    begin
                        if (sub_write_reg != SUB_STALL)
                        begin
                            if (success_seen_reg)
                            begin
                                success_seen_next = 1'b0;
                                if (sub_write_reg == SUB_GAIN)
                                begin
                                    sub_write_next   = SUB_ID;
                                    entry_index_next = entry_index_reg + 4'd1;
                                    skip_req         = 1'b1;
                                end
                                else
                                begin
                                    sub_sel        = sub_write_reg + 2'd1;
                                    sub_write_next = sub_sel;
                                end
                            end
                            if (!awaiting_reply_reg && !skip_req)
                            begin
                                sent = 1'b1;
                                case (sub_sel)
                                    SUB_ID:
                                        sent_payload = {row[31:0], 6'd0, sub_sel,
                                                        IDX_MAP_ENTRY, dir, CMD_WRITE4};
                                    SUB_LAYOUT:
                                        sent_payload = {row[63:32], 6'd0, sub_sel,
                                                        IDX_MAP_ENTRY, dir, CMD_WRITE4};
                                    default:
                                        sent_payload = {16'h0, GAIN_OFFSET, 6'd0, sub_sel,
                                                        IDX_MAP_ENTRY, dir, CMD_WRITE4};
                                endcase
                            end
                        end
                    end
                    else
                    begin
                        awaiting_reply_next = 1'b0;
                        sub_write_next      = SUB_ID;
                        entry_index_next    = 4'd0;
                        if (phase_reg == PH_RX_MAP)
                            success_seen_next = 1'b0;
                        phase_next = phase_t'(phase_reg + 3'd1);
                    end
                end
                PH_SAVE:
                begin
                    if (!awaiting_reply_reg && !success_seen_reg)
                    begin
                        sent         = 1'b1;
                        sent_payload = {40'h0, IDX_SAVE, DIR_SAVE, CMD_WRITE4};
                    end
                    else if (success_seen_reg)
                    begin
                        phase_next = PH_DONE;
                    end
                end
                default:
                begin
                    done = 1'b1;
                end
            endcase
            if (sent)
                awaiting_reply_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg          <= PH_CLEAR_TX;
            sub_write_reg      <= SUB_ID;
            entry_index_reg    <= 4'd0;
            awaiting_reply_reg <= 1'b0;
            empty_seen_reg     <= 1'b0;
            success_seen_reg   <= 1'b0;
            abort_run_reg      <= 8'd0;
        end
        else if (accept)
        begin
            phase_reg          <= phase_next;
            sub_write_reg      <= sub_write_next;
            entry_index_reg    <= entry_index_next;
            awaiting_reply_reg <= awaiting_reply_next;
            empty_seen_reg     <= empty_seen_next;
            success_seen_reg   <= success_seen_next;
            abort_run_reg      <= abort_run_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            node_id_reg <= 7'd1;
        else if (cfg_we)
            node_id_reg <= cfg_wdata;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (accept)
            out_valid_reg <= 1'b1;
        else if (out_ch.ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            send_frame_reg  <= sent;
            frame_id_reg    <= sent ? (SDO_REQ_BASE + {4'd0, node_id_reg}) : 11'd0;
            payload_reg     <= sent_payload;
            config_done_reg <= done;
        end
    end

    assign out_ch.valid       = out_valid_reg;
    assign out_ch.send_frame  = send_frame_reg;
    assign out_ch.frame_id    = frame_id_reg;
    assign out_ch.payload     = payload_reg;
    assign out_ch.config_done = config_done_reg;

    a_send_or_done: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> !(send_frame_reg && config_done_reg))
        else $error("frame and done in one word");

    a_id_with_frame: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> ((frame_id_reg != 11'd0) == send_frame_reg))
        else $error("frame id does not match send flag");

    a_send_waits: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && sent) |=> awaiting_reply_reg)
        else $error("request sent without waiting for reply");

    a_abort_done: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && in_ch.func && awaiting_reply_reg && in_ch.reply_code == REPLY_ABORT
         && abort_run_reg >= ABORT_LIMIT && abort_run_reg != 8'hFF)
        |=> phase_reg == PH_DONE)
        else $error("abort run did not end sequence");

endmodule
